FILE: hw/rtl/lsb_stego_codec_assert.svh
// Assertion macros for the LSB steganography codec.
// Expects signals named clock and reset in the including module.
`ifndef LSB_STEGO_CODEC_ASSERT_SVH
`define LSB_STEGO_CODEC_ASSERT_SVH

// Checked outside reset.
`define LSC_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/lsc_pkg.sv
// Shared types and constants for the LSB steganography codec.
// No dependencies.
package lsc_pkg;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_TERM   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSB_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINATOR = 3'd4;

   localparam logic       MODE_EMBED       = 1'b0;
   localparam logic       MODE_EXTRACT     = 1'b1;
   localparam logic [7:0] HEADER_RESET     = 8'd44;
   localparam logic [7:0] TERMINATOR_RESET = 8'd0;

endpackage

FILE: hw/rtl/lsc_channels.sv
// Valid/ready channel interfaces for the codec's carrier input and result output.
// Standalone; used by lsb_stego_codec.
interface lsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] carrier_byte;
   logic [7:0] message_byte;
   logic       message_end;

   modport source (output valid, output carrier_byte, output message_byte,
                   output message_end, input ready);
   modport sink   (input valid, input carrier_byte, input message_byte,
                   input message_end, output ready);
endinterface

interface lsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] carrier_out;
   logic       took_message;
   logic       char_valid;
   logic [7:0] char_out;
   logic       done_res;

   modport source (output valid, output carrier_out, output took_message,
                   output char_valid, output char_out, output done_res, input ready);
   modport sink   (input valid, input carrier_out, input took_message,
                   input char_valid, input char_out, input done_res, output ready);
endinterface

FILE: hw/rtl/lsb_stego_codec.sv
// LSB steganography codec: embeds or extracts message bits in carrier byte LSBs.
// Depends on lsc_pkg, lsc_channels.sv and lsb_stego_codec_assert.svh.
//
// Usage:
//   req_bus carries one carrier byte per beat, plus the current message byte
//   and message_end flag (only looked at when a new character starts in embed
//   mode). rsp_bus returns one beat per input beat, in order.
//   csr_wr_en/csr_index/csr_wr_data write mode, msb_first, header_bytes,
//   skip_bytes and terminator; write only while the block is idle.
//   Path: a beat sits in the input register, then the state update and
//   result are computed into the result register, from which the result is
//   offered on rsp_bus until it is taken.
//   Throughput: one beat per cycle unless rsp_bus stalls; state steps per beat.
//   Stall: when rsp_bus.ready is low the result holds and one more beat can be
//   taken into the input register; req_bus.ready then drops until space frees.
//   Reset: synchronous; clears both stages, the position counters and returns
//   the registers to their defaults (embed, MSB first, 44-byte header, no skip,
//   terminator 0).
`include "lsb_stego_codec_assert.svh"

module lsb_stego_codec
   import lsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lsc_req_if.sink                req_bus,
   lsc_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // configuration
   logic       mode_ff, msb_first_ff;
   logic [7:0] header_bytes_ff, terminator_ff;
   logic [3:0] skip_bytes_ff;

   // stream state
   logic [7:0] header_count_ff, header_count_in;
   logic [3:0] skip_count_ff, skip_count_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] char_shift_ff, char_shift_in;
   phase_type  phase_ff, phase_in;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_carrier_ff, s1_message_ff;
   logic       s1_end_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_carrier_ff, out_carrier_in;
   logic       out_took_ff, out_took_in;
   logic       out_cvalid_ff, out_cvalid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_done_ff, out_done_in;

   logic out_ready, req_accept, advance;

   assign out_ready   = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || out_ready;
   assign req_accept  = req_bus.valid && req_bus.ready;
   assign advance     = s1_valid_ff && out_ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_comb begin
      phase_type  ph_cur;
      phase_type  ph_emb;
      logic       load;
      logic [7:0] shift_v;
      logic [7:0] base;
      logic [7:0] assembled;
      logic [2:0] pos;
      logic [2:0] bi_next;

      header_count_in = header_count_ff;
      skip_count_in   = skip_count_ff;
      bit_index_in    = bit_index_ff;
      char_shift_in   = char_shift_ff;
      phase_in        = phase_ff;
      out_carrier_in  = s1_carrier_ff;
      out_took_in     = 1'b0;
      out_cvalid_in   = 1'b0;
      out_char_in     = 8'd0;
      out_done_in     = 1'b0;

      ph_cur    = (phase_ff == PH_HEADER) ? PH_ACTIVE : phase_ff;
      load      = (bit_index_ff == 3'd0) && (ph_cur == PH_ACTIVE);
      shift_v   = load ? (s1_end_ff ? terminator_ff : s1_message_ff) : char_shift_ff;
      ph_emb    = (load && s1_end_ff) ? PH_TERM : ph_cur;
      pos       = msb_first_ff ? (3'd7 - bit_index_ff) : bit_index_ff;
      bi_next   = bit_index_ff + 3'd1;
      base      = (bit_index_ff == 3'd0) ? 8'd0 : char_shift_ff;
      assembled = msb_first_ff ? {base[6:0], s1_carrier_ff[0]}
                               : (base | (8'(s1_carrier_ff[0]) << bit_index_ff));

      priority if (phase_ff == PH_HEADER && header_count_ff < header_bytes_ff) begin
         header_count_in = header_count_ff + 8'd1;
      end else if (ph_cur == PH_DONE) begin
         out_done_in = 1'b1;
      end else if (skip_count_ff < skip_bytes_ff) begin
         phase_in      = ph_cur;
         skip_count_in = skip_count_ff + 4'd1;
      end else if (mode_ff == MODE_EMBED) begin
         skip_count_in  = 4'd0;
         char_shift_in  = shift_v;
         out_took_in    = load && !s1_end_ff;
         out_carrier_in = {s1_carrier_ff[7:1], shift_v[pos]};
         bit_index_in   = bi_next;
         if (bi_next == 3'd0 && ph_emb == PH_TERM) begin
            phase_in    = PH_DONE;
            out_done_in = 1'b1;
         end else begin
            phase_in = ph_emb;
         end
      end else begin
         skip_count_in = 4'd0;
         bit_index_in  = bi_next;
         char_shift_in = assembled;
         phase_in      = ph_cur;
         if (bi_next == 3'd0) begin
            char_shift_in = 8'd0;
            if (assembled == terminator_ff) begin
               phase_in    = PH_DONE;
               out_done_in = 1'b1;
            end else begin
               out_cvalid_in = 1'b1;
               out_char_in   = assembled;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_EMBED;
         msb_first_ff    <= 1'b1;
         header_bytes_ff <= HEADER_RESET;
         skip_bytes_ff   <= 4'd0;
         terminator_ff   <= TERMINATOR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff         <= csr_wr_data[0];
            CSR_MSB_FIRST:  msb_first_ff    <= csr_wr_data[0];
            CSR_HEADER:     header_bytes_ff <= csr_wr_data;
            CSR_SKIP:       skip_bytes_ff   <= csr_wr_data[3:0];
            CSR_TERMINATOR: terminator_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= 8'd0;
         skip_count_ff   <= 4'd0;
         bit_index_ff    <= 3'd0;
         char_shift_ff   <= 8'd0;
         phase_ff        <= PH_HEADER;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            header_count_ff <= header_count_in;
            skip_count_ff   <= skip_count_in;
            bit_index_ff    <= bit_index_in;
            char_shift_ff   <= char_shift_in;
            phase_ff        <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_carrier_ff <= req_bus.carrier_byte;
         s1_message_ff <= req_bus.message_byte;
         s1_end_ff     <= req_bus.message_end;
      end
      if (advance) begin
         out_carrier_ff <= out_carrier_in;
         out_took_ff    <= out_took_in;
         out_cvalid_ff  <= out_cvalid_in;
         out_char_ff    <= out_char_in;
         out_done_ff    <= out_done_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.carrier_out  = out_carrier_ff;
   assign rsp_bus.took_message = out_took_ff;
   assign rsp_bus.char_valid   = out_cvalid_ff;
   assign rsp_bus.char_out     = out_char_ff;
   assign rsp_bus.done_res     = out_done_ff;

   // done is sticky and its beats carry nothing else
   `LSC_ASSERT_RUN(a_done_sticky, phase_ff == PH_DONE |=> phase_ff == PH_DONE, "left done phase")
   `LSC_ASSERT_RUN(a_done_beat, (phase_ff == PH_DONE && advance) |=>
      (out_valid_ff && out_done_ff && !out_took_ff && !out_cvalid_ff), "done beat carries payload")
   `LSC_ASSERT_RUN(a_embed_extract_excl, out_valid_ff |-> !(out_took_ff && out_cvalid_ff),
      "embed and extract in one beat")
   `LSC_ASSERT_RUN(a_char_zero, (out_valid_ff && !out_cvalid_ff) |-> out_char_ff == 8'd0,
      "char_out not cleared")
   `LSC_ASSERT_ALWAYS(a_reset_empty, reset |=> (!out_valid_ff && !s1_valid_ff), "pipeline not empty after reset")

endmodule
